@@ sv/pef_pkg.sv @@
`default_nettype none
package pef_pkg;

  localparam int POINTS          = 16;
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int MASK_W          = 16;
  localparam int IDX_W           = $clog2(MASK_W + 1);
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);

  localparam logic [31:0] EPB_TYPE        = 32'd6;
  localparam logic [15:0] EPB_FIXED_BYTES = 16'd32;
  localparam logic [15:0] PAD_MASK        = 16'd3;
  localparam logic [15:0] RECORD_LIMIT_RESET = 16'd4096;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CONFIGURED = 2'd0;
  localparam logic [1:0] REG_ACTIVE     = 2'd1;
  localparam logic [1:0] REG_LIMIT      = 2'd2;

  // word positions inside one queue entry
  localparam logic [3:0] POS_TYPE    = 4'd0;
  localparam logic [3:0] POS_TOTAL   = 4'd1;
  localparam logic [3:0] POS_IFACE   = 4'd2;
  localparam logic [3:0] POS_TS_HI   = 4'd3;
  localparam logic [3:0] POS_TS_LO   = 4'd4;
  localparam logic [3:0] POS_CAPLEN  = 4'd5;
  localparam logic [3:0] POS_ORIGLEN = 4'd6;
  localparam logic [3:0] POS_DATA    = 4'd7;
  localparam logic [3:0] POS_TRAILER = 4'd8;

  typedef struct packed {
    logic             hdr;    // emit the seven header words
    logic             dat;    // emit one data word
    logic             trl;    // emit the trailing total length
    logic [15:0]      total;
    logic [IDX_W-1:0] idx;
    logic [63:0]      ts;
    logic [11:0]      len;
    logic [31:0]      word;
  } pef_entry_t;

  // number of configured points below the given point
  function automatic logic [IDX_W-1:0] index_below(input logic [MASK_W-1:0] mask,
                                                   input logic [3:0] point);
    logic [IDX_W-1:0] cnt;
    cnt = '0;
    for (int p = 0; p < MASK_W; p++) begin
      if (p < int'(point) && mask[p]) begin
        cnt = cnt + IDX_W'(1);
      end
    end
    return cnt;
  endfunction

endpackage
`default_nettype wire

@@ sv/pef_front.sv @@
`default_nettype none
module pef_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic [3:0]          point_id,
  input  wire logic [63:0]         stamp,
  input  wire logic [11:0]         frame_length,
  input  wire logic [7:0]          data_byte,
  input  wire logic                first_byte,
  input  wire logic                final_byte,
  input  wire logic                cfg_fire,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output logic                     push,
  output pef_pkg::pef_entry_t      entry
);

  logic [15:0] configured_mask;
  logic [15:0] active_mask;
  logic [15:0] record_limit;

  logic [15:0] record_count, record_count_next;
  logic        frame_admitted, frame_admitted_next;
  logic [23:0] word_assembly, word_assembly_next;
  logic [1:0]  byte_lane, byte_lane_next;
  logic [15:0] block_total, block_total_next;

  logic        ok;
  logic        adm_cur;
  logic [23:0] asm_cur;
  logic [1:0]  lane_cur;
  logic [15:0] total_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      configured_mask <= '0;
      active_mask     <= '0;
      record_limit    <= pef_pkg::RECORD_LIMIT_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        pef_pkg::REG_CONFIGURED: configured_mask <= cfg_data;
        pef_pkg::REG_ACTIVE:     active_mask     <= cfg_data;
        pef_pkg::REG_LIMIT:      record_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ok = (int'(point_id) < pef_pkg::POINTS) &&
         configured_mask[point_id] && active_mask[point_id] &&
         (record_count < record_limit) &&
         (frame_length != 12'd0) && (int'(frame_length) <= pef_pkg::MAX_FRAME_BYTES);
    total_new = pef_pkg::EPB_FIXED_BYTES +
                ((16'(frame_length) + pef_pkg::PAD_MASK) & ~pef_pkg::PAD_MASK);

    adm_cur  = first_byte ? ok : frame_admitted;
    asm_cur  = first_byte ? 24'd0 : word_assembly;
    lane_cur = first_byte ? 2'd0 : byte_lane;

    record_count_next   = record_count;
    block_total_next    = block_total;
    frame_admitted_next = adm_cur;
    word_assembly_next  = asm_cur;
    byte_lane_next      = lane_cur;

    entry       = '0;
    entry.total = first_byte ? total_new : block_total;
    entry.idx   = pef_pkg::index_below(configured_mask, point_id);
    entry.ts    = stamp;
    entry.len   = frame_length;

    if (first_byte && ok) begin
      record_count_next = record_count + 16'd1;
      block_total_next  = total_new;
      entry.hdr         = 1'b1;
    end

    if (adm_cur) begin
      if (lane_cur == 2'd3) begin
        entry.dat          = 1'b1;
        entry.word         = {data_byte, asm_cur};
        word_assembly_next = '0;
        byte_lane_next     = 2'd0;
      end else begin
        word_assembly_next = asm_cur | (24'(data_byte) << {lane_cur, 3'b000});
        byte_lane_next     = lane_cur + 2'd1;
      end
      if (final_byte) begin
        // flush the partial word, zero padded
        if (byte_lane_next != 2'd0) begin
          entry.dat  = 1'b1;
          entry.word = {8'd0, word_assembly_next};
        end
        entry.trl           = 1'b1;
        word_assembly_next  = '0;
        byte_lane_next      = 2'd0;
        frame_admitted_next = 1'b0;
      end
    end

    push = in_fire && (entry.hdr || entry.dat || entry.trl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count   <= '0;
      frame_admitted <= 1'b0;
      word_assembly  <= '0;
      byte_lane      <= '0;
      block_total    <= '0;
    end else if (in_fire) begin
      record_count   <= record_count_next;
      frame_admitted <= frame_admitted_next;
      word_assembly  <= word_assembly_next;
      byte_lane      <= byte_lane_next;
      block_total    <= block_total_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/pef_queue.sv @@
`default_nettype none
module pef_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pef_pkg::pef_entry_t push_entry,
  input  wire logic                pop,
  output pef_pkg::pef_entry_t      head,
  output logic                     empty,
  output logic                     full
);

  pef_pkg::pef_entry_t slots [pef_pkg::QDEPTH];
  logic [pef_pkg::QPTR_W-1:0] wr_ptr;
  logic [pef_pkg::QPTR_W-1:0] rd_ptr;
  logic [pef_pkg::QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (pef_pkg::QPTR_W+1)'(pef_pkg::QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pef_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pef_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (pef_pkg::QPTR_W+1)'(1);
        2'b01:   count <= count - (pef_pkg::QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/pef_back.sv @@
`default_nettype none
module pef_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pef_pkg::pef_entry_t head,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,
  output logic                     m_tlast
);

  logic [3:0]  pos, pos_next;
  logic [3:0]  eff;
  logic        done;
  logic        load;
  logic        fire;
  logic [31:0] word;

  assign load = !m_tvalid || m_tready;
  assign fire = load && !empty;

  always_comb begin
    if (pos == pef_pkg::POS_TYPE && !head.hdr) begin
      eff = head.dat ? pef_pkg::POS_DATA : pef_pkg::POS_TRAILER;
    end else begin
      eff = pos;
    end

    unique case (eff)
      pef_pkg::POS_TYPE:    word = pef_pkg::EPB_TYPE;
      pef_pkg::POS_TOTAL:   word = 32'(head.total);
      pef_pkg::POS_IFACE:   word = 32'(head.idx);
      pef_pkg::POS_TS_HI:   word = head.ts[63:32];
      pef_pkg::POS_TS_LO:   word = head.ts[31:0];
      pef_pkg::POS_CAPLEN,
      pef_pkg::POS_ORIGLEN: word = 32'(head.len);
      pef_pkg::POS_DATA:    word = head.word;
      default:              word = 32'(head.total);
    endcase

    done     = 1'b0;
    pos_next = eff + 4'd1;
    if (eff == pef_pkg::POS_ORIGLEN) begin
      if (head.dat) begin
        pos_next = pef_pkg::POS_DATA;
      end else if (head.trl) begin
        pos_next = pef_pkg::POS_TRAILER;
      end else begin
        done = 1'b1;
      end
    end else if (eff == pef_pkg::POS_DATA) begin
      if (head.trl) begin
        pos_next = pef_pkg::POS_TRAILER;
      end else begin
        done = 1'b1;
      end
    end else if (eff == pef_pkg::POS_TRAILER) begin
      done = 1'b1;
    end
    if (done) begin
      pos_next = pef_pkg::POS_TYPE;
    end
    pop = fire && done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= pef_pkg::POS_TYPE;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        pos <= pos_next;
      end
      if (load) begin
        m_tvalid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= word;
      m_tlast <= (eff == pef_pkg::POS_TRAILER);
    end
  end

endmodule
`default_nettype wire

@@ sv/pcapng_epb_capture_framer_top.sv @@
`default_nettype none
// Channel  | Dir | Handshake           | Payload
// s_*      | in  | s_tvalid/s_tready   | tdata: point, timestamp, length, byte;
//          |     |                     | tuser: first byte; tlast: final byte
// m_*      | out | m_tvalid/m_tready   | tdata: block word; tlast: trailer word
// cfg_*    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (16 bits)
//
// One byte is taken per cycle while the four-entry command queue has room.
// The back end sends one block word per cycle while m_tready is high; a frame
// of L bytes gives 8 + ceil(L/4) words, so the output paces short frames.
// Reset is synchronous; masks clear, the record limit returns to 4096.
// Either side may stall; the queue and the output register decouple them.
module pcapng_epb_capture_framer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,   // [3:0] point, [67:4] timestamp,
                                      // [79:68] frame_length, [87:80] data_byte
  input  wire logic        s_tuser,   // [0] first_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] out_word
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  pef_pkg::pef_entry_t push_entry;
  pef_pkg::pef_entry_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic in_fire;

  // hold input while the queue is full; config is always taken
  assign s_tready  = !full;
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;

  pef_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .point_id      (s_tdata[3:0]),
    .stamp         (s_tdata[67:4]),
    .frame_length  (s_tdata[79:68]),
    .data_byte     (s_tdata[87:80]),
    .first_byte    (s_tuser),
    .final_byte    (s_tlast),
    .cfg_fire      (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .entry         (push_entry)
  );

  pef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  pef_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
